>>> hdl/hcrp_pkg.sv
package hcrp_pkg;

  localparam int unsigned MIN_RECORD = 23;
  localparam int unsigned MAX_RECORD = 4096;

  localparam logic [15:0] POS_VERSION  = 16'd0;
  localparam logic [15:0] POS_LEN_SIZE = 16'd21;
  localparam logic [15:0] POS_NUM_ARR  = 16'd22;
  localparam logic [7:0]  VERSION_ONE  = 8'd1;

  localparam logic [5:0] NAL_VPS = 6'd32;
  localparam logic [5:0] NAL_SPS = 6'd33;
  localparam logic [5:0] NAL_PPS = 6'd34;

  localparam logic [1:0] SET_VPS = 2'd0;
  localparam logic [1:0] SET_SPS = 2'd1;
  localparam logic [1:0] SET_PPS = 2'd2;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MISSING   = 2'd1;
  localparam logic [1:0] ST_BAD_VER   = 2'd2;
  localparam logic [1:0] ST_BAD_SIZE  = 2'd3;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_ARR_TYPE = 4'd1,
    PH_CNT_HI   = 4'd2,
    PH_CNT_LO   = 4'd3,
    PH_LEN_HI   = 4'd4,
    PH_LEN_LO   = 4'd5,
    PH_DATA     = 4'd6,
    PH_DONE     = 4'd7,
    PH_BADVER   = 4'd8
  } phase_t;

  typedef struct packed {
    logic       item_kind;
    logic [1:0] set_kind;
    logic [7:0] data_byte;
    logic       set_last;
    logic [2:0] length_field_size;
    logic [1:0] status;
    logic       run_last;
  } res_t;

  typedef struct packed {
    logic data_vld;
    res_t data;
    logic stat_vld;
    res_t stat;
  } push_t;

endpackage

>>> hdl/hcrp_parser.sv
module hcrp_parser (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_record_size,
  input  logic           step_en,
  input  logic [7:0]     step_byte,
  output hcrp_pkg::push_t push
);
  import hcrp_pkg::*;

  logic [15:0] rsize_r, rsize_nxt;
  logic [15:0] pos_r, pos_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  arrays_r, arrays_nxt;
  logic [15:0] units_r, units_nxt;
  logic [5:0]  type_r, type_nxt;
  logic [15:0] ubl_r, ubl_nxt;
  logic [7:0]  lhb_r, lhb_nxt;
  logic [2:0]  flags_r, flags_nxt;
  logic        capt_r, capt_nxt;
  logic [2:0]  lfs_r, lfs_nxt;
  logic        stop_r, stop_nxt;

  logic        active, size_ok, last_byte;
  logic [16:0] off, off2, off_len;
  logic [15:0] len;
  logic [7:0]  arrays_dec;
  phase_t      na_phase;
  logic        set_hit;
  logic [1:0]  set_idx;
  logic [16:0] rsize_x;

  assign rsize_x    = {1'b0, rsize_r};
  assign active     = step_en && !stop_r && (pos_r < rsize_r);
  assign size_ok    = (rsize_r >= 16'(MIN_RECORD)) && (rsize_r <= 16'(MAX_RECORD));
  assign off        = {1'b0, pos_r} + 17'd1;
  assign off2       = off + 17'd2;
  assign len        = {lhb_r, step_byte};
  assign off_len    = off + {1'b0, len};
  assign last_byte  = (off == rsize_x);
  assign arrays_dec = arrays_r - 8'd1;
  assign na_phase   = (arrays_dec == 8'd0 || off >= rsize_x) ? PH_DONE : PH_ARR_TYPE;

  always_comb begin
    set_hit = 1'b1;
    set_idx = SET_VPS;
    case (type_r)
      NAL_VPS: set_idx = SET_VPS;
      NAL_SPS: set_idx = SET_SPS;
      NAL_PPS: set_idx = SET_PPS;
      default: set_hit = 1'b0;
    endcase
  end

  // next state of the parse
  always_comb begin
    logic [15:0] units_v;
    logic        go_unit;
    rsize_nxt  = rsize_r;
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    arrays_nxt = arrays_r;
    units_nxt  = units_r;
    type_nxt   = type_r;
    ubl_nxt    = ubl_r;
    lhb_nxt    = lhb_r;
    flags_nxt  = flags_r;
    capt_nxt   = capt_r;
    lfs_nxt    = lfs_r;
    stop_nxt   = stop_r;
    units_v    = units_r;
    go_unit    = 1'b0;

    if (cfg_we) begin
      rsize_nxt  = cfg_record_size;
      pos_nxt    = '0;
      phase_nxt  = PH_HEADER;
      arrays_nxt = '0;
      units_nxt  = '0;
      type_nxt   = '0;
      ubl_nxt    = '0;
      lhb_nxt    = '0;
      flags_nxt  = '0;
      capt_nxt   = 1'b0;
      lfs_nxt    = '0;
      stop_nxt   = 1'b0;
    end else if (active) begin
      if (size_ok) begin
        case (phase_r)
          PH_HEADER: begin
            if (pos_r == POS_VERSION && step_byte != VERSION_ONE) begin
              phase_nxt = PH_BADVER;
            end else if (pos_r == POS_LEN_SIZE) begin
              lfs_nxt = {1'b0, step_byte[1:0]} + 3'd1;
            end else if (pos_r == POS_NUM_ARR) begin
              arrays_nxt = step_byte;
              phase_nxt  = (step_byte == 8'd0 || off >= rsize_x) ? PH_DONE : PH_ARR_TYPE;
            end
          end
          PH_ARR_TYPE: begin
            type_nxt  = step_byte[5:0];
            phase_nxt = (off2 > rsize_x) ? PH_DONE : PH_CNT_HI;
          end
          PH_CNT_HI, PH_LEN_HI: begin
            lhb_nxt   = step_byte;
            phase_nxt = (phase_r == PH_CNT_HI) ? PH_CNT_LO : PH_LEN_LO;
          end
          PH_CNT_LO: begin
            units_v   = len;
            units_nxt = len;
            go_unit   = 1'b1;
          end
          PH_LEN_LO: begin
            units_v   = units_r - 16'd1;
            units_nxt = units_v;
            if (off_len > rsize_x) begin
              arrays_nxt = arrays_dec;
              phase_nxt  = na_phase;
            end else if (len == 16'd0) begin
              go_unit = 1'b1;
            end else begin
              capt_nxt = set_hit && !flags_r[set_idx];
              if (set_hit) flags_nxt[set_idx] = 1'b1;
              ubl_nxt   = len;
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            ubl_nxt = ubl_r - 16'd1;
            if (ubl_r == 16'd1) begin
              capt_nxt = 1'b0;
              go_unit  = 1'b1;
            end
          end
          default: begin
          end
        endcase
        // start of the next NAL, or the next array when this one is used up
        if (go_unit) begin
          if (units_v == 16'd0 || off2 > rsize_x) begin
            arrays_nxt = arrays_dec;
            phase_nxt  = na_phase;
          end else begin
            phase_nxt = PH_LEN_HI;
          end
        end
      end
      pos_nxt = off[15:0];
      if (last_byte) stop_nxt = 1'b1;
    end
  end

  // result items for this byte
  always_comb begin
    push = '0;
    if (!cfg_we && active) begin
      if (size_ok && phase_r == PH_DATA && capt_r) begin
        push.data_vld       = 1'b1;
        push.data.item_kind = KIND_DATA;
        push.data.set_kind  = set_hit ? set_idx : SET_VPS;
        push.data.data_byte = step_byte;
        push.data.set_last  = (ubl_r == 16'd1);
        push.data.run_last  = !last_byte;
      end
      if (last_byte) begin
        push.stat_vld       = 1'b1;
        push.stat.item_kind = KIND_STATUS;
        push.stat.run_last  = 1'b1;
        if (!size_ok) begin
          push.stat.status = ST_BAD_SIZE;
        end else if (phase_r == PH_BADVER ||
                     (phase_r == PH_HEADER && pos_r == POS_VERSION &&
                      step_byte != VERSION_ONE)) begin
          push.stat.status = ST_BAD_VER;
        end else begin
          push.stat.length_field_size = lfs_nxt;
          push.stat.status = (flags_nxt[2:1] == 2'b11) ? ST_OK : ST_MISSING;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsize_r  <= '0;
      pos_r    <= '0;
      phase_r  <= PH_HEADER;
      arrays_r <= '0;
      units_r  <= '0;
      type_r   <= '0;
      ubl_r    <= '0;
      lhb_r    <= '0;
      flags_r  <= '0;
      capt_r   <= 1'b0;
      lfs_r    <= '0;
      stop_r   <= 1'b0;
    end else begin
      rsize_r  <= rsize_nxt;
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      arrays_r <= arrays_nxt;
      units_r  <= units_nxt;
      type_r   <= type_nxt;
      ubl_r    <= ubl_nxt;
      lhb_r    <= lhb_nxt;
      flags_r  <= flags_nxt;
      capt_r   <= capt_nxt;
      lfs_r    <= lfs_nxt;
      stop_r   <= stop_nxt;
    end
  end

endmodule

>>> hdl/hevc_config_record_parser.sv
// hvcC record parser. Write cfg_record_size, then stream the record one byte per
// transaction. Bytes of the first non-empty VPS, SPS and PPS come out tagged, with
// set_last on each set's final byte; a status transaction follows the record's final
// byte. The block takes one byte per cycle while the result queue has room; a byte
// passes an input register and the parse step, then its results wait in a four-entry
// result queue. A byte yields up to two results and the queue drains one per cycle
// while out_ready is high, so a final parameter-set byte yields a data result and
// then the status result. Bytes past the record end are accepted and dropped.
module hevc_config_record_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_record_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_record_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_item_kind,
  output logic [1:0]  out_set_kind,
  output logic [7:0]  out_data_byte,
  output logic        out_set_last,
  output logic [2:0]  out_length_field_size,
  output logic [1:0]  out_status,
  output logic        out_run_last
);
  import hcrp_pkg::*;

  logic       hold_vld_r, hold_vld_nxt;
  logic [7:0] hold_byte_r;
  logic       proc;
  push_t      push;

  res_t       q_mem [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] push_n;
  res_t       head;

  // process only when the queue has room for two results
  assign proc     = hold_vld_r && (cnt_r <= 3'd2);
  assign in_ready = !hold_vld_r || proc;

  always_comb begin
    hold_vld_nxt = hold_vld_r;
    if (proc) hold_vld_nxt = 1'b0;
    if (in_valid && in_ready) hold_vld_nxt = 1'b1;
  end

  hcrp_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_record_size (cfg_record_size),
    .step_en         (proc),
    .step_byte       (hold_byte_r),
    .push            (push)
  );

  assign head      = q_mem[rd_ptr_r];
  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && out_ready;
  assign push_n    = {1'b0, push.data_vld} + {1'b0, push.stat_vld};

  assign wr_ptr_nxt = wr_ptr_r + push_n;
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  assign cnt_nxt    = cnt_r + {1'b0, push_n} - {2'b0, pop};

  assign out_item_kind         = head.item_kind;
  assign out_set_kind          = head.set_kind;
  assign out_data_byte         = head.data_byte;
  assign out_set_last          = head.set_last;
  assign out_length_field_size = head.length_field_size;
  assign out_status            = head.status;
  assign out_run_last          = head.run_last;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) hold_byte_r <= in_record_byte;
    if (push.data_vld) q_mem[wr_ptr_r] <= push.data;
    if (push.stat_vld) q_mem[wr_ptr_r + {1'b0, push.data_vld}] <= push.stat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      hold_vld_r <= hold_vld_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule
